[hw/rtl/conv2d_valid_window_top_assert.svh]
// ----------------------------------------------------------------------------
// conv2d_valid_window_top assertion macros
// Concurrent assertion shorthands used by the checker file cv2_checker.
// ----------------------------------------------------------------------------
`ifndef CONV2D_VALID_WINDOW_TOP_ASSERT_SVH
`define CONV2D_VALID_WINDOW_TOP_ASSERT_SVH

// same-cycle implication
`define CV2_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CV2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cv2_pkg.sv]
// ----------------------------------------------------------------------------
// cv2_pkg
// Shared constants and types of the valid-region 2D cross-correlation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cv2_pkg;

    localparam int KERNEL_ROWS = 3;
    localparam int KERNEL_COLS = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;

    localparam int KSIZE     = KERNEL_ROWS * KERNEL_COLS;
    localparam int LINE_ROWS = KERNEL_ROWS - 1;

    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SUM_W      = 35;
    localparam int IDX_W      = 4;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int LINE_W     = LINE_ROWS * SAMPLE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // request codes
    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // position tag that travels with each sample through the pipeline
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cv2_tag_t;

endpackage

[hw/rtl/conv2d_valid_window_top.sv]
// ----------------------------------------------------------------------------
// conv2d_valid_window_top
// Streaming 3x3 valid-region cross-correlation over a row-major pixel stream.
// ----------------------------------------------------------------------------
// Takes one item (weight load or image sample) per clock cycle while the
// output is not stalled. A sample's result passes through these registers in
// order: the transfer edge registers the line memory read, then the window
// shift and the multiplier in each cell, the row adders, and the final adder
// into the output register. A stalled result holds the whole pipeline and the
// input. Weight loads and samples can be mixed freely; a sample uses the
// weights loaded before it. The line memory needs no clearing pass: entries
// are always written before they reach a result. Writing a size register
// restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv2d_valid_window_top
    import cv2_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [IDX_W-1:0]      weight_index,
    input  sample_t               sample_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sum_t                  conv_value,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,
    output logic                  frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic adv;
    logic in_xfer;
    logic sample_xfer;
    logic weight_xfer;
    logic cfg_xfer;

    logic [WIDTH_W-1:0]  width_reg;
    logic [WIDTH_W-1:0]  width_next;
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] height_next;
    logic [COL_W-1:0]    col_count_reg;
    logic [COL_W-1:0]    col_count_next;
    logic [ROW_W-1:0]    row_count_reg;
    logic [ROW_W-1:0]    row_count_next;
    logic                col_last;
    logic                row_last;

    cv2_tag_t s1_tag_reg;
    cv2_tag_t s1_tag_next;
    sample_t  s1_px_reg;
    cv2_tag_t s2_tag_reg;
    cv2_tag_t s3_tag;
    sum_t     s3_total;

    logic [LINE_W-1:0] line_rd;
    logic [LINE_W-1:0] line_wr;

    sample_t win  [KERNEL_ROWS][KERNEL_COLS];
    prod_t   prod [KERNEL_ROWS][KERNEL_COLS];

    logic             out_valid_reg;
    sum_t             conv_value_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             frame_last_reg;

    assign adv         = !out_valid_reg || !out_stall;
    assign in_stall    = !adv;
    assign in_xfer     = in_valid && !in_stall;
    assign sample_xfer = in_xfer && (req_type == REQ_SAMPLE);
    assign weight_xfer = in_xfer && (req_type == REQ_WEIGHT);
    assign cfg_ready   = 1'b1;
    assign cfg_xfer    = cfg_valid && cfg_ready &&
                         (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

    // size registers, clamped on write
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_WIDTH)
        begin
            if (cfg_data[10:0] < 11'(KERNEL_COLS))
                width_next = WIDTH_W'(KERNEL_COLS);
            else if (cfg_data[10:0] > 11'(MAX_WIDTH))
                width_next = WIDTH_W'(MAX_WIDTH);
            else
                width_next = WIDTH_W'(cfg_data[10:0]);
        end
        if (cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_HEIGHT)
        begin
            if (cfg_data[12:0] < 13'(KERNEL_ROWS))
                height_next = HEIGHT_W'(KERNEL_ROWS);
            else if (cfg_data[12:0] > 13'(MAX_HEIGHT))
                height_next = HEIGHT_W'(MAX_HEIGHT);
            else
                height_next = HEIGHT_W'(cfg_data[12:0]);
        end
    end

    // position counters
    assign col_last = ({1'b0, col_count_reg} + 1'b1) == (COL_W + 1)'(width_reg);
    assign row_last = ({1'b0, row_count_reg} + 1'b1) == (ROW_W + 1)'(height_reg);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_xfer)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (sample_xfer)
        begin
            if (col_last)
            begin
                col_count_next = '0;
                row_count_next = row_last ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_tag_next.valid = sample_xfer;
        s1_tag_next.emit  = (row_count_reg >= ROW_W'(KERNEL_ROWS - 1)) &&
                            (col_count_reg >= COL_W'(KERNEL_COLS - 1));
        s1_tag_next.last  = col_last && row_last;
        s1_tag_next.row   = row_count_reg;
        s1_tag_next.col   = col_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_W'(MAX_WIDTH);
            height_reg    <= HEIGHT_W'(MAX_HEIGHT);
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_tag_reg    <= '0;
            s2_tag_reg    <= '0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (adv)
            begin
                s1_tag_reg <= s1_tag_next;
                s2_tag_reg <= s1_tag_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            s1_px_reg <= sample_value;
        end
    end

    // line memory: read at transfer, column written back one row up
    cv2_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (sample_xfer),
        .rd_addr (col_count_reg),
        .rd_data (line_rd),
        .wr_en   (adv && s1_tag_reg.valid),
        .wr_addr (s1_tag_reg.col),
        .wr_data (line_wr)
    );

    always_comb
    begin
        for (int i = 0; i < LINE_ROWS - 1; i++)
        begin
            line_wr[i*SAMPLE_W +: SAMPLE_W] = line_rd[(i+1)*SAMPLE_W +: SAMPLE_W];
        end
        line_wr[(LINE_ROWS-1)*SAMPLE_W +: SAMPLE_W] = s1_px_reg;
    end

    // window cells
    for (genvar r = 0; r < KERNEL_ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < KERNEL_COLS; c++)
        begin : g_col
            sample_t cell_in;

            if (c < KERNEL_COLS - 1)
            begin : g_mid
                assign cell_in = win[r][c+1];
            end
            else if (r < LINE_ROWS)
            begin : g_line
                assign cell_in = line_rd[r*SAMPLE_W +: SAMPLE_W];
            end
            else
            begin : g_new
                assign cell_in = s1_px_reg;
            end

            cv2_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .load_en     (weight_xfer && weight_index == IDX_W'(r * KERNEL_COLS + c)),
                .load_weight (sample_value),
                .shift_en    (adv && s1_tag_reg.valid),
                .sample_in   (cell_in),
                .sample_out  (win[r][c]),
                .product     (prod[r][c])
            );
        end
    end

    cv2_sum u_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .prod    (prod),
        .tag_in  (s2_tag_reg),
        .total   (s3_total),
        .tag_out (s3_tag)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_tag.valid && s3_tag.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            conv_value_reg <= s3_total;
            out_row_reg    <= s3_tag.row - ROW_W'(KERNEL_ROWS - 1);
            out_col_reg    <= s3_tag.col - COL_W'(KERNEL_COLS - 1);
            frame_last_reg <= s3_tag.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign conv_value = conv_value_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

endmodule

[hw/rtl/cv2_cell.sv]
// ----------------------------------------------------------------------------
// cv2_cell
// One window position: holds its kernel weight and sample, takes the sample
// of its right neighbor on a shift and registers the weighted product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cv2_cell
    import cv2_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load_en,
    input  sample_t load_weight,
    input  logic    shift_en,
    input  sample_t sample_in,
    output sample_t sample_out,
    output prod_t   product
);

    sample_t weight_reg;
    sample_t sample_reg;
    prod_t   product_reg;
    prod_t   product_next;

    assign product_next = weight_reg * sample_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            sample_reg <= '0;
        end
        else
        begin
            if (load_en)
            begin
                weight_reg <= load_weight;
            end
            if (shift_en)
            begin
                sample_reg <= sample_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            product_reg <= product_next;
        end
    end

    assign sample_out = sample_reg;
    assign product    = product_reg;

endmodule

[hw/rtl/cv2_line_buf.sv]
// ----------------------------------------------------------------------------
// cv2_line_buf
// Line memory: one word per column holding the buffered image rows, with a
// registered read port and one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cv2_line_buf
    import cv2_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [COL_W-1:0]  rd_addr,
    output logic [LINE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] line_mem_reg [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/cv2_sum.sv]
// ----------------------------------------------------------------------------
// cv2_sum
// Adder stages: registered per-row sums of the cell products, then the
// window total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cv2_sum
    import cv2_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  prod_t    prod [KERNEL_ROWS][KERNEL_COLS],
    input  cv2_tag_t tag_in,
    output sum_t     total,
    output cv2_tag_t tag_out
);

    sum_t     row_sum_reg  [KERNEL_ROWS];
    sum_t     row_sum_next [KERNEL_ROWS];
    cv2_tag_t tag_reg;

    always_comb
    begin
        for (int r = 0; r < KERNEL_ROWS; r++)
        begin
            row_sum_next[r] = '0;
            for (int c = 0; c < KERNEL_COLS; c++)
            begin
                row_sum_next[r] = row_sum_next[r] + SUM_W'(prod[r][c]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int r = 0; r < KERNEL_ROWS; r++)
        begin
            total = total + row_sum_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_sum_reg <= row_sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out = tag_reg;

endmodule

[hw/rtl/cv2_checker.sv]
// ----------------------------------------------------------------------------
// cv2_checker
// Port-level checks of conv2d_valid_window_top, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "conv2d_valid_window_top_assert.svh"

module cv2_checker
    import cv2_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input sum_t             conv_value,
    input logic [ROW_W-1:0] out_row,
    input logic [COL_W-1:0] out_col,
    input logic             frame_last
);

    `CV2_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(conv_value) && $stable(out_row) && $stable(out_col) && $stable(frame_last), "stalled result changed")

    `CV2_ASSERT_NOW(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while output free")

    `CV2_ASSERT_NOW(a_pos_range, clk, rst_n, out_valid, out_col <= COL_W'(MAX_WIDTH - KERNEL_COLS) && out_row <= ROW_W'(MAX_HEIGHT - KERNEL_ROWS), "result position outside valid region")

    `CV2_ASSERT_NOW(a_reset_quiet, clk, rst_n, !$past(rst_n), !out_valid, "result right after reset")

endmodule

bind conv2d_valid_window_top cv2_checker u_cv2_checker (.*);

[dv/tb_conv2d_valid_window_top.sv]
// ----------------------------------------------------------------------------
// tb_conv2d_valid_window_top
// Self-checking bench for the streaming 3x3 valid-region cross-correlation.
// ----------------------------------------------------------------------------
// A clocked driver feeds weight loads and image samples from a queue. Each
// transfer updates a bench-side copy of the kernel, line rows and window, and
// queues any result it should cause. A clocked monitor checks each output
// transfer in order. Frame sizes change between phases while the block is
// idle, out-of-range sizes included. Sender gaps, receiver stall patterns, a
// long output hold and a full drain pause are mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_conv2d_valid_window_top
    import cv2_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam sample_t S_MIN = 16'sh8000;
    localparam sample_t S_MAX = 16'sh7FFF;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 40;
    localparam int WIDE_ITEMS   = 40;

    typedef struct packed {
        logic             rtype;
        logic [IDX_W-1:0] idx;
        sample_t          val;
    } stream_item_t;

    typedef struct {
        sum_t             value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } conv_result_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  req_type     = REQ_WEIGHT;
    logic [IDX_W-1:0]      weight_index = '0;
    sample_t               sample_value = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    sum_t                  conv_value;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  frame_last;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // bench copy of the block state
    logic [10:0]  size_width  = 11'd1024;
    logic [12:0]  size_height = 13'd4096;
    sample_t      kern [KSIZE];
    sample_t      win [KSIZE];
    sample_t      line_buf [LINE_ROWS][MAX_WIDTH];
    int unsigned  row_pos = 0;
    int unsigned  col_pos = 0;

    stream_item_t pending_q [$];
    conv_result_t conv_expect_q [$];
    int           items_sent  = 0;
    int           items_taken = 0;
    int           err_cnt     = 0;

    int           burst_left = 0;
    int           gap_left   = 0;
    bit           tx_gaps    = 1'b1;
    int           rx_mode    = 0;
    int           pat_cnt    = 0;
    int           hold_req   = 0;
    int           hold_seen  = 0;
    int           hold_left  = 0;

    conv2d_valid_window_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .weight_index (weight_index),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .conv_value   (conv_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        foreach (kern[i])
        begin
            kern[i] = '0;
            win[i]  = '0;
        end
    end

    function automatic sample_t rand_val();
        case ($urandom_range(0, 7))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic apply_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_IMAGE_WIDTH)
            size_width = data[10:0];
        else if (idx == CFG_IMAGE_HEIGHT)
            size_height = data[12:0];
        else
            return;
        row_pos = 0;
        col_pos = 0;
    endtask

    // one transfer into the correlator: weight load or sample
    task automatic correlate_step(input logic rtype, input logic [IDX_W-1:0] idx,
                                  input sample_t px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        logic signed [63:0] acc;
        conv_result_t res;
        if (rtype == REQ_WEIGHT)
        begin
            if (idx < KSIZE)
                kern[idx] = px;
            return;
        end
        w = 32'(size_width);
        h = 32'(size_height);
        if (w < KERNEL_COLS) w = KERNEL_COLS;
        if (w > MAX_WIDTH)   w = MAX_WIDTH;
        if (h < KERNEL_ROWS) h = KERNEL_ROWS;
        if (h > MAX_HEIGHT)  h = MAX_HEIGHT;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        for (int i = 0; i < KERNEL_ROWS; i++)
            for (int j = 0; j + 1 < KERNEL_COLS; j++)
                win[i * KERNEL_COLS + j] = win[i * KERNEL_COLS + j + 1];
        for (int i = 0; i < LINE_ROWS; i++)
            win[i * KERNEL_COLS + KERNEL_COLS - 1] = line_buf[i][c];
        win[KSIZE - 1] = px;
        for (int i = 0; i + 1 < LINE_ROWS; i++)
            line_buf[i][c] = line_buf[i + 1][c];
        line_buf[LINE_ROWS - 1][c] = px;

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;

        if (r + 1 < KERNEL_ROWS || c + 1 < KERNEL_COLS)
            return;
        acc = '0;
        for (int i = 0; i < KSIZE; i++)
            acc = acc + 64'(kern[i]) * 64'(win[i]);
        res.value = acc[SUM_W-1:0];
        res.row   = ROW_W'(r - (KERNEL_ROWS - 1));
        res.col   = COL_W'(c - (KERNEL_COLS - 1));
        res.last  = (r + 1 == h) && (c + 1 == w);
        conv_expect_q.push_back(res);
    endtask

    // sender: bursts with random gaps
    always @(posedge clk)
    begin : tx_drive
        stream_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                correlate_step(req_type, weight_index, sample_value);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    nxt = pending_q.pop_front();
                    req_type     <= nxt.rtype;
                    weight_index <= nxt.idx;
                    sample_value <= nxt.val;
                    in_valid     <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = (tx_gaps && $urandom_range(0, 2) == 0) ?
                                   $urandom_range(1, 12) : 0;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with an occasional long hold
    always @(posedge clk)
    begin : rx_stall
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            pat_cnt++;
            case (rx_mode)
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ((pat_cnt % 5) < 2);
                3: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin : rx_check
        conv_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (conv_expect_q.size() == 0)
            begin
                $error("unexpected result transfer: row %0d col %0d value %0d",
                       out_row, out_col, conv_value);
                err_cnt++;
            end
            else
            begin
                want = conv_expect_q.pop_front();
                if (conv_value !== want.value)
                begin
                    $error("conv_value: expected %0d, got %0d", want.value, conv_value);
                    err_cnt++;
                end
                if (out_row !== want.row)
                begin
                    $error("out_row: expected %0d, got %0d", want.row, out_row);
                    err_cnt++;
                end
                if (out_col !== want.col)
                begin
                    $error("out_col: expected %0d, got %0d", want.col, out_col);
                    err_cnt++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0b, got %0b", want.last, frame_last);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push_item(input logic rtype, input logic [IDX_W-1:0] idx,
                             input sample_t val);
        stream_item_t it;
        it.rtype = rtype;
        it.idx   = idx;
        it.val   = val;
        pending_q.push_back(it);
        items_sent++;
    endtask

    task automatic push_random_item();
        if ($urandom_range(0, 99) < 12)
            push_item(REQ_WEIGHT, ($urandom_range(0, 99) < 85) ?
                      IDX_W'($urandom_range(0, KSIZE - 1)) :
                      IDX_W'($urandom_range(KSIZE, 15)), rand_val());
        else
            push_item(REQ_SAMPLE, IDX_W'($urandom), rand_val());
    endtask

    task automatic wait_drained();
        while (items_taken != items_sent)
            @(posedge clk);
        while (conv_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_size_reg(idx, data);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] wdat,
                             input logic [CFG_DATA_W-1:0] hdat);
        wait_idle();
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_IMAGE_WIDTH, wdat);
            write_reg(CFG_IMAGE_HEIGHT, hdat);
        end
        else
        begin
            write_reg(CFG_IMAGE_HEIGHT, hdat);
            write_reg(CFG_IMAGE_WIDTH, wdat);
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] wdat;
        logic [CFG_DATA_W-1:0] hdat;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // 3x3 frame; upper data bits lie outside both registers
        set_frame(16'hF803, 16'hE003);
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h0000);

        // largest positive sum, ignored loads, then a fresh weight
        for (int i = 0; i < KSIZE; i++)
            push_item(REQ_WEIGHT, IDX_W'(i), S_MIN);
        push_item(REQ_WEIGHT, 4'd15, S_MAX);
        push_item(REQ_WEIGHT, 4'd9, S_MAX);
        for (int i = 0; i < KSIZE; i++)
            push_item(REQ_SAMPLE, '0, S_MIN);
        push_item(REQ_WEIGHT, 4'd4, S_MAX);
        for (int i = 0; i < KSIZE; i++)
            push_item(REQ_SAMPLE, '1, (i == 4) ? S_MIN : S_MAX);

        for (int p = 0; p < PHASES; p++)
        begin
            wdat = (p == 0) ? 16'd0 : (p == 1) ? 16'd2 : 16'($urandom_range(3, 8));
            hdat = (p == 2) ? 16'd0 : (p == 3) ? 16'd1 : 16'($urandom_range(3, 6));
            set_frame(wdat, hdat);
            rx_mode = p % 4;
            tx_gaps = (p % 3 != 0);
            if (p == 4)
                tx_gaps = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                push_random_item();
                if (p == 6 && i == PHASE_ITEMS / 2)
                    wait_drained();
            end
            if (p == 4)
            begin
                @(posedge clk);
                hold_req++;
            end
        end

        // widest frame, width clamped from above, height clamped from below
        set_frame(16'h07FF, 16'h0000);
        rx_mode = 1;
        tx_gaps = 1'b1;
        for (int i = 0; i < KSIZE; i++)
            push_item(REQ_WEIGHT, IDX_W'(i), rand_val());
        for (int i = 0; i < WIDE_ITEMS; i++)
            push_item(REQ_SAMPLE, IDX_W'($urandom), rand_val());

        // tallest frame, only its first rows
        set_frame(16'd3, 16'd4096);
        rx_mode = 2;
        for (int i = 0; i < 40; i++)
            push_random_item();

        set_frame(16'd1024, 16'h1FFF);
        rx_mode = 0;
        for (int i = 0; i < 10; i++)
            push_item(REQ_SAMPLE, IDX_W'($urandom), rand_val());

        wait_idle();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[conv2d_valid_window_top.f]
+incdir+hw/rtl
hw/rtl/cv2_pkg.sv
hw/rtl/cv2_cell.sv
hw/rtl/cv2_line_buf.sv
hw/rtl/cv2_sum.sv
hw/rtl/conv2d_valid_window_top.sv
hw/rtl/cv2_checker.sv
dv/tb_conv2d_valid_window_top.sv
